### hw/rtl/rhp_pkg.sv
package rhp_pkg;

	localparam int CNT_W         = 32;
	localparam int LF_W          = 24;
	localparam int FRAC_W        = 16;
	localparam int GROWTH_FACTOR = 2;
	localparam int ROM_SIZE      = 66;
	localparam int PRIME_ENTRIES = 66;
	localparam int ROM_N         = (PRIME_ENTRIES < ROM_SIZE) ? PRIME_ENTRIES : ROM_SIZE;
	localparam int REPAIR_STEPS  = 8;
	localparam int MIN_BUCKETS   = 2;
	localparam int ROM_W         = 32;
	localparam int PROD_W        = CNT_W + LF_W;
	localparam int DIV_W         = CNT_W + FRAC_W;
	localparam int IDX_W         = $clog2(ROM_N + 1);
	localparam int ADDR_W        = $clog2(ROM_N);
	localparam int STEP_W        = $clog2(REPAIR_STEPS + 1);

	localparam logic [CNT_W-1:0] CMAX       = '1;
	localparam logic [CNT_W-1:0] GROW_LIMIT = CMAX / GROWTH_FACTOR;
	localparam logic [LF_W-1:0]  LF_RESET   = LF_W'(65536);

	localparam logic OP_PICK  = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	typedef enum logic [3:0] {
		ST_FILL,
		ST_IDLE,
		ST_FIT0,
		ST_FIT1,
		ST_DIV,
		ST_WANT,
		ST_SRD,
		ST_SCMP,
		ST_REP0,
		ST_REP1,
		ST_REP2
	} state_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_W-1:0]     quotient;
		logic [LF_W-1:0]      remainder;
	} div_status_t;

	localparam logic [ROM_W-1:0] PRIME_ROM [ROM_SIZE] = '{
		32'd2, 32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd17, 32'd23, 32'd29, 32'd37,
		32'd47, 32'd59, 32'd73, 32'd97, 32'd137, 32'd193, 32'd271, 32'd383, 32'd541,
		32'd761, 32'd1069, 32'd1499, 32'd2099, 32'd2939, 32'd4127, 32'd5779, 32'd8093,
		32'd11351, 32'd15901, 32'd22271, 32'd31181, 32'd43661, 32'd61129, 32'd85597,
		32'd119839, 32'd167777, 32'd234893, 32'd328883, 32'd460451, 32'd644647,
		32'd902507, 32'd1263511, 32'd1768927, 32'd2476511, 32'd3467117, 32'd4853983,
		32'd6795587, 32'd9513839, 32'd13319431, 32'd18647231, 32'd26106131,
		32'd36548621, 32'd51168071, 32'd71635303, 32'd100289437, 32'd140405297,
		32'd196567433, 32'd275194417, 32'd385272187, 32'd539381069, 32'd755133497,
		32'd1057186937, 32'd1480061717, 32'd2072086411, 32'd2900920991,
		32'd4061289391
	};

endpackage

### hw/rtl/rhp_ram.sv
module rhp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/rhp_div.sv
module rhp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rhp_pkg::DIV_W-1:0] dividend,
	input  logic [rhp_pkg::LF_W-1:0]  divisor,
	output rhp_pkg::div_status_t      status
);
	import rhp_pkg::*;

	localparam int CNT_BITS = $clog2(DIV_W + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DIV_W-1:0]    rq_q;
	logic [LF_W-1:0]     rem_q;
	logic [LF_W-1:0]     dv_q;
	logic [LF_W:0]       trial;
	logic                qbit;

	// Restoring division, one quotient bit per cycle; the dividend shifts out
	// of the top of rq_q while quotient bits shift in at the bottom.
	assign trial = {rem_q, rq_q[DIV_W-1]};
	assign qbit  = (trial >= {1'b0, dv_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rq_q  <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rq_q <= {rq_q[DIV_W-2:0], qbit};
			if (qbit) begin
				rem_q <= LF_W'(trial - {1'b0, dv_q});
			end else begin
				rem_q <= trial[LF_W-1:0];
			end
		end
	end

	assign status.done      = done_q;
	assign status.quotient  = rq_q;
	assign status.remainder = rem_q;

endmodule

### hw/rtl/hash_table_rehash_policy_top.sv
// Channel  Handshake              Payload
// req      req_valid / req_stall  opcode, requested_count, cur_buckets, element_count,
//                                 insert_count
// rsp      rsp_valid / rsp_stall  grow, next_buckets, resize_threshold
// cfg      cfg_valid / cfg_ready  cfg_data (elements per bucket limit, 16 fraction bits)
//
// One request at a time. Opcode 0 runs a binary search over the prime memory, each
// probe with its registered read, then one multiply. Opcode 1 finishes after the fit
// check when the elements fit; otherwise the divider (skipped when the load factor is
// zero), the search and up to 8 repair steps follow.
// After reset the prime memory is loaded, one entry a cycle, and req_stall stays
// high until that is done. A stalled response holds the result register; the block
// may accept the next request meanwhile and waits to finish it.
module hash_table_rehash_policy_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic                      opcode,
	input  logic [rhp_pkg::CNT_W-1:0] requested_count,
	input  logic [rhp_pkg::CNT_W-1:0] cur_buckets,
	input  logic [rhp_pkg::CNT_W-1:0] element_count,
	input  logic [rhp_pkg::CNT_W-1:0] insert_count,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic                      grow,
	output logic [rhp_pkg::CNT_W-1:0] next_buckets,
	output logic [rhp_pkg::CNT_W-1:0] resize_threshold,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rhp_pkg::LF_W-1:0]  cfg_data
);
	import rhp_pkg::*;

	state_t              state_q, state_d;
	logic [LF_W-1:0]     lf_q;
	logic [ADDR_W-1:0]   fill_q;
	logic                rsp_valid_q;
	logic                grow_q;
	logic [CNT_W-1:0]    nbc_q;
	logic [CNT_W-1:0]    thr_q;

	logic [CNT_W-1:0]    need_q;
	logic [CNT_W-1:0]    bkt_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    want_q;
	logic [CNT_W-1:0]    mb_q;
	logic [IDX_W-1:0]    lo_q, hi_q, mid_q, idx_q;
	logic [ROM_W-1:0]    cand_q;
	logic [STEP_W-1:0]   steps_q;
	logic [PROD_W-1:0]   prod_q;

	logic                accept;
	logic                out_free;
	logic                fits_c;
	logic                fin_c;
	logic [CNT_W-1:0]    thr_c;
	logic [CNT_W:0]      need_sum;
	logic [CNT_W-1:0]    need_c;
	logic [CNT_W-1:0]    grown_c;
	logic [IDX_W-1:0]    mid_c;
	logic [IDX_W-1:0]    idx_nx;
	logic [DIV_W:0]      q_ceil;
	logic [CNT_W-1:0]    mb_c;
	logic [CNT_W-1:0]    w1_c;
	logic [CNT_W-1:0]    req_n;
	logic                fill_last;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [ROM_W-1:0]    ram_rdata;
	logic                div_start;
	logic                res_load;
	div_status_t         div_st;

	rhp_ram #(
		.WIDTH(ROM_W),
		.DEPTH(ROM_N)
	) u_prime_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q),
		.wdata(PRIME_ROM[fill_q]),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rhp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({need_q, {FRAC_W{1'b0}}}),
		.divisor (lf_q),
		.status  (div_st)
	);

	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign fill_last = (fill_q == ADDR_W'(ROM_N - 1));

	// need * 2^16 <= buckets * load factor, compared exactly.
	assign fits_c = {{(PROD_W-DIV_W){1'b0}}, need_q, {FRAC_W{1'b0}}} <= prod_q;
	assign thr_c  = (|prod_q[PROD_W-1:DIV_W]) ? CMAX : prod_q[DIV_W-1:FRAC_W];
	assign fin_c  = (steps_q == '0) || fits_c || (bkt_q == CMAX);

	assign need_sum = {1'b0, element_count} + {1'b0, insert_count};
	assign need_c   = need_sum[CNT_W] ? CMAX : need_sum[CNT_W-1:0];
	assign req_n    = (requested_count < CNT_W'(MIN_BUCKETS)) ?
		CNT_W'(MIN_BUCKETS) : requested_count;
	assign grown_c  = (bkt_q < GROW_LIMIT) ? bkt_q * CNT_W'(GROWTH_FACTOR) : CMAX;

	assign mid_c  = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_nx = idx_q + IDX_W'(1);

	// Ceiling of the quotient, saturated to the count range.
	assign q_ceil = {1'b0, div_st.quotient} + (DIV_W+1)'(div_st.remainder != '0);
	assign mb_c   = (|q_ceil[DIV_W:CNT_W]) ? CMAX : q_ceil[CNT_W-1:0];
	assign w1_c   = (want_q < mb_q) ? mb_q : want_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (fill_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = (opcode == OP_CHECK) ? ST_FIT0 : ST_SRD;
			end
			ST_FIT0: state_d = ST_FIT1;
			ST_FIT1: begin
				if (fits_c) begin
					if (out_free) state_d = ST_IDLE;
				end else if (lf_q == '0) begin
					state_d = ST_WANT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_st.done) state_d = ST_WANT;
			end
			ST_WANT: state_d = ST_SRD;
			ST_SRD:  state_d = (lo_q >= hi_q) ? ST_REP0 : ST_SCMP;
			ST_SCMP: state_d = ST_SRD;
			ST_REP0: state_d = ST_REP1;
			ST_REP1: begin
				if (fin_c) begin
					if (out_free) state_d = ST_IDLE;
				end else if (idx_q >= IDX_W'(ROM_N - 1)) begin
					state_d = ST_REP0;
				end else begin
					state_d = ST_REP2;
				end
			end
			ST_REP2: state_d = ST_REP0;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		ram_we    = (state_q == ST_FILL);
		ram_raddr = '0;
		div_start = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			ST_FIT1: begin
				div_start = !fits_c && (lf_q != '0);
				res_load  = fits_c && out_free;
			end
			ST_SRD:  ram_raddr = mid_c[ADDR_W-1:0];
			ST_REP1: begin
				ram_raddr = idx_nx[ADDR_W-1:0];
				res_load  = fin_c && out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			lf_q        <= LF_RESET;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) lf_q <= cfg_data;
			if (state_q == ST_FILL && !fill_last) fill_q <= fill_q + ADDR_W'(1);
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(bkt_q) * PROD_W'(lf_q);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					lo_q <= '0;
					hi_q <= IDX_W'(ROM_N);
					if (opcode == OP_CHECK) begin
						bkt_q   <= cur_buckets;
						need_q  <= need_c;
						steps_q <= STEP_W'(REPAIR_STEPS);
					end else begin
						n_q     <= req_n;
						steps_q <= '0;
					end
				end
			end
			ST_FIT1: begin
				want_q <= grown_c;
				mb_q   <= CMAX;
			end
			ST_DIV: begin
				if (div_st.done) mb_q <= mb_c;
			end
			ST_WANT: begin
				n_q  <= (w1_c < CNT_W'(MIN_BUCKETS)) ? CNT_W'(MIN_BUCKETS) : w1_c;
				lo_q <= '0;
				hi_q <= IDX_W'(ROM_N);
			end
			ST_SRD: begin
				mid_q <= mid_c;
				if (lo_q >= hi_q) begin
					// Past the last prime the target itself is the answer.
					bkt_q <= (hi_q == IDX_W'(ROM_N)) ? n_q : cand_q;
					idx_q <= hi_q;
				end
			end
			ST_SCMP: begin
				if (ram_rdata < n_q) begin
					lo_q <= mid_q + IDX_W'(1);
				end else begin
					hi_q   <= mid_q;
					cand_q <= ram_rdata;
				end
			end
			ST_REP1: begin
				if (!fin_c && idx_q >= IDX_W'(ROM_N - 1)) begin
					bkt_q   <= bkt_q + CNT_W'(1);
					idx_q   <= IDX_W'(ROM_N);
					steps_q <= steps_q - STEP_W'(1);
				end
			end
			ST_REP2: begin
				bkt_q   <= ram_rdata;
				idx_q   <= idx_nx;
				steps_q <= steps_q - STEP_W'(1);
			end
			default: ;
		endcase
		if (res_load) begin
			thr_q <= thr_c;
			if (state_q == ST_FIT1) begin
				grow_q <= 1'b0;
				nbc_q  <= '0;
			end else begin
				grow_q <= 1'b1;
				nbc_q  <= bkt_q;
			end
		end
	end

	assign cfg_ready        = 1'b1;
	assign rsp_valid        = rsp_valid_q;
	assign grow             = grow_q;
	assign next_buckets     = nbc_q;
	assign resize_threshold = thr_q;

endmodule
